// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker in ccts_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CCTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CCTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ccts_pkg.sv =====
`default_nettype none
package ccts_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned FREQ_W   = 10;
  localparam int unsigned PART_W   = 10;
  localparam int unsigned TOTAL_W  = 64;
  localparam int unsigned REM_W    = 30;
  localparam int unsigned PC_W     = 3;
  localparam int unsigned CNT_W    = 6;

  localparam logic [FREQ_W-1:0] FREQ_RESET = 10'd168;
  localparam logic [19:0]       US_PER_S   = 20'd1000000;
  localparam logic [9:0]        MS_PER_S   = 10'd1000;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_DIV     = 3'd1,
    OP_LOAD_MS = 3'd2,
    OP_LOAD_US = 3'd3,
    OP_MUL     = 3'd4,
    OP_EMIT    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    C_NEXT     = 2'd0,
    C_WAIT_IN  = 2'd1,
    C_LOOP     = 2'd2,
    C_WAIT_OUT = 2'd3
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [PC_W-1:0]  target;
    logic [CNT_W-1:0] cnt;
  } ctl_word_t;

  typedef struct packed {
    logic               load;
    logic               step;
    logic [REM_W-1:0]   r0;
    logic [TOTAL_W-1:0] q0;
    logic [REM_W-1:0]   d;
  } div_ctl_t;

  // Microprogram. A condition that holds jumps to target, else pc + 1.
  // The last step falls through to step 0 by pc wrap.
  function automatic ctl_word_t ccts_rom(input logic [PC_W-1:0] pc);
    ctl_word_t w;
    w = '{op: OP_LOAD, cond: C_NEXT, target: 3'd0, cnt: 6'd0};
    case (pc)
      3'd0: w = '{op: OP_LOAD,    cond: C_WAIT_IN,  target: 3'd0, cnt: 6'd63};
      3'd1: w = '{op: OP_DIV,     cond: C_LOOP,     target: 3'd1, cnt: 6'd0};
      3'd2: w = '{op: OP_LOAD_MS, cond: C_NEXT,     target: 3'd0, cnt: 6'd9};
      3'd3: w = '{op: OP_DIV,     cond: C_LOOP,     target: 3'd3, cnt: 6'd0};
      3'd4: w = '{op: OP_LOAD_US, cond: C_NEXT,     target: 3'd0, cnt: 6'd9};
      3'd5: w = '{op: OP_DIV,     cond: C_LOOP,     target: 3'd5, cnt: 6'd0};
      3'd6: w = '{op: OP_MUL,     cond: C_NEXT,     target: 3'd0, cnt: 6'd0};
      3'd7: w = '{op: OP_EMIT,    cond: C_WAIT_OUT, target: 3'd7, cnt: 6'd0};
      default: w = '{op: OP_LOAD, cond: C_NEXT, target: 3'd0, cnt: 6'd0};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ccts_if.sv =====
`default_nettype none
interface ccts_sample_if import ccts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] counter_sample;
  modport source (output valid, output counter_sample, input ready);
  modport sink (input valid, input counter_sample, output ready);
endinterface

interface ccts_time_if import ccts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [31:0]        seconds;
  logic [PART_W-1:0]  millis;
  logic [PART_W-1:0]  micros;
  logic [TOTAL_W-1:0] total_micros;
  modport source (output valid, output seconds, output millis, output micros,
                  output total_micros, input ready);
  modport sink (input valid, input seconds, input millis, input micros,
                input total_micros, output ready);
endinterface

interface ccts_cfg_if import ccts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] core_mhz;
  modport source (output valid, output core_mhz, input ready);
  modport sink (input valid, input core_mhz, output ready);
endinterface
`default_nettype wire

// ===== hdl/ccts_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per step.
module ccts_div import ccts_pkg::*; (
  input  wire logic               clk,
  input  wire div_ctl_t           ctl,
  output logic [TOTAL_W-1:0]      q,
  output logic [REM_W-1:0]        r
);

  logic [REM_W-1:0]   r_r, r_nxt;
  logic [TOTAL_W-1:0] q_r, q_nxt;
  logic [REM_W-1:0]   d_r, d_nxt;
  logic [REM_W:0]     trial;
  logic               ge;

  always_comb begin
    trial = {r_r, q_r[TOTAL_W-1]};
    ge    = trial >= {1'b0, d_r};
    r_nxt = r_r;
    q_nxt = q_r;
    d_nxt = d_r;
    if (ctl.load) begin
      r_nxt = ctl.r0;
      q_nxt = ctl.q0;
      d_nxt = ctl.d;
    end else if (ctl.step) begin
      r_nxt = ge ? REM_W'(trial - {1'b0, d_r}) : trial[REM_W-1:0];
      q_nxt = {q_r[TOTAL_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    r_r <= r_nxt;
    q_r <= q_nxt;
    d_r <= d_nxt;
  end

  assign q = q_r;
  assign r = r_r;

endmodule
`default_nettype wire

// ===== hdl/cycle_count_timeline_split_unit.sv =====
`default_nettype none
// Channel   Dir  Payload                                     Handshake
// in_ch     in   counter_sample[31:0]                        valid/ready
// out_ch    out  seconds, millis, micros, total_micros       valid/ready
// cfg_ch    in   core_mhz[9:0]                               valid/ready (ready out of reset)
//
// One request in flight: after acceptance it runs the 64-step divide by hertz, then two
// 10-step divides in the shared divider, before the result register is loaded.
// Next request is taken the cycle after the result is loaded.
// rst_n (sync) clears counting state, sequencer and core_mhz (168).
// A stalled result holds in the output register; the sequencer waits at its last step.
module cycle_count_timeline_split_unit import ccts_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ccts_sample_if.sink in_ch,
  ccts_time_if.source out_ch,
  ccts_cfg_if.sink    cfg_ch
);

  ctl_word_t          ctl;
  logic [PC_W-1:0]    pc_r, pc_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [FREQ_W-1:0]  mhz_r;
  logic [31:0]        wrap_r, last_r, wrap_inc;
  logic [31:0]        secs_r;
  logic [PART_W-1:0]  ms_r, us_r;
  logic [TOTAL_W-1:0] prod_r;
  logic               out_vld_r;
  logic [31:0]        o_sec_r;
  logic [PART_W-1:0]  o_ms_r, o_us_r;
  logic [TOTAL_W-1:0] o_tot_r;

  logic [FREQ_W-1:0]  mhz_eff;
  logic [REM_W-1:0]   hz, per_ms;
  logic [19:0]        ms_scaled;
  logic               in_acc, out_free, emit, jump;
  div_ctl_t           dctl;
  logic [TOTAL_W-1:0] div_q;
  logic [REM_W-1:0]   div_r;

  assign ctl       = ccts_rom(pc_r);
  assign mhz_eff   = (mhz_r == '0) ? FREQ_W'(1) : mhz_r;
  assign hz        = REM_W'({20'd0, mhz_eff} * {10'd0, US_PER_S});
  assign per_ms    = REM_W'({20'd0, mhz_eff} * {20'd0, MS_PER_S});
  assign ms_scaled = {10'd0, ms_r} * {10'd0, MS_PER_S};

  assign cfg_ch.ready = rst_n;
  assign in_ch.ready  = (ctl.op == OP_LOAD) && rst_n;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_vld_r || out_ch.ready;
  assign emit         = (ctl.op == OP_EMIT) && out_free;
  assign wrap_inc     = wrap_r + 32'(in_ch.counter_sample < last_r);

  always_comb begin
    dctl = '{load: 1'b0, step: 1'b0, r0: '0, q0: '0, d: hz};
    case (ctl.op)
      OP_LOAD: begin
        dctl.load = in_acc;
        dctl.q0   = {wrap_inc, in_ch.counter_sample};
      end
      OP_DIV: begin
        dctl.step = 1'b1;
      end
      OP_LOAD_MS: begin
        dctl.load = 1'b1;
        dctl.r0   = {10'd0, div_r[REM_W-1:10]};
        dctl.q0   = {div_r[9:0], 54'd0};
        dctl.d    = per_ms;
      end
      OP_LOAD_US: begin
        dctl.load = 1'b1;
        dctl.r0   = {10'd0, div_r[REM_W-1:10]};
        dctl.q0   = {div_r[9:0], 54'd0};
        dctl.d    = {20'd0, mhz_eff};
      end
      default: begin
        dctl.load = 1'b0;
      end
    endcase
  end

  ccts_div u_div (
    .clk (clk),
    .ctl (dctl),
    .q   (div_q),
    .r   (div_r)
  );

  always_comb begin
    case (ctl.cond)
      C_WAIT_IN:  jump = !in_ch.valid;
      C_LOOP:     jump = (cnt_r != '0);
      C_WAIT_OUT: jump = !out_free;
      default:    jump = 1'b0;
    endcase
    pc_nxt = jump ? ctl.target : pc_r + PC_W'(1);
    cnt_nxt = cnt_r;
    if (ctl.op == OP_DIV) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end else if (ctl.op != OP_EMIT && ctl.op != OP_MUL) begin
      cnt_nxt = ctl.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= '0;
      cnt_r     <= '0;
      mhz_r     <= FREQ_RESET;
      wrap_r    <= '0;
      last_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      pc_r  <= pc_nxt;
      cnt_r <= cnt_nxt;
      if (cfg_ch.valid) begin
        mhz_r <= cfg_ch.core_mhz;
      end
      if (in_acc) begin
        wrap_r <= wrap_inc;
        last_r <= in_ch.counter_sample;
      end
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_LOAD_MS) begin
      secs_r <= div_q[31:0];
    end
    if (ctl.op == OP_LOAD_US) begin
      ms_r <= div_q[PART_W-1:0];
    end
    if (ctl.op == OP_MUL) begin
      us_r   <= div_q[PART_W-1:0];
      prod_r <= {32'd0, secs_r} * {44'd0, US_PER_S};
    end
    if (emit) begin
      o_sec_r <= secs_r;
      o_ms_r  <= ms_r;
      o_us_r  <= us_r;
      o_tot_r <= prod_r + {44'd0, ms_scaled} + {54'd0, us_r};
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.seconds      = o_sec_r;
  assign out_ch.millis       = o_ms_r;
  assign out_ch.micros       = o_us_r;
  assign out_ch.total_micros = o_tot_r;

endmodule
`default_nettype wire

// ===== hdl/ccts_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module ccts_checker import ccts_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [31:0]        seconds,
  input wire logic [PART_W-1:0]  millis,
  input wire logic [PART_W-1:0]  micros,
  input wire logic [TOTAL_W-1:0] total_micros
);

  `CCTS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(seconds) && $stable(total_micros), "result changed while stalled")
  `CCTS_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "request taken while busy")
  `CCTS_ASSERT_IMP(a_parts_range, clk, rst_n, out_valid, millis <= 10'd999 && micros <= 10'd999, "millis or micros out of range")
  `CCTS_ASSERT_IMP(a_total_sum, clk, rst_n, out_valid, total_micros == ({32'd0, seconds} * 64'd1000000 + {54'd0, millis} * 64'd1000 + {54'd0, micros}), "total_micros mismatch")

endmodule

bind cycle_count_timeline_split_unit ccts_checker u_ccts_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .seconds      (out_ch.seconds),
  .millis       (out_ch.millis),
  .micros       (out_ch.micros),
  .total_micros (out_ch.total_micros)
);
`default_nettype wire

// ===== bench/testbench.sv =====
module testbench;
  import ccts_pkg::*;

  typedef struct packed {
    logic [31:0]        seconds;
    logic [PART_W-1:0]  millis;
    logic [PART_W-1:0]  micros;
    logic [TOTAL_W-1:0] total_micros;
  } time_split_t;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned DRAIN_CYCLES  = 120;
  localparam int unsigned PHASE_SAMPLES = 55;
  localparam int unsigned NUM_SETTINGS  = 7;

  logic clk;
  logic rst_n;

  ccts_sample_if in_ch();
  ccts_time_if   out_ch();
  ccts_cfg_if    cfg_ch();

  cycle_count_timeline_split_unit u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // predictor state
  logic [FREQ_W-1:0]   model_mhz   = FREQ_RESET;
  logic [31:0]         wraps_seen  = '0;
  logic [SAMPLE_W-1:0] prev_sample = '0;

  logic [SAMPLE_W-1:0] queued_samples[$];
  time_split_t         pending_times[$];

  int unsigned mismatch_count = 0;
  int unsigned samples_sent   = 0;
  int unsigned results_seen   = 0;
  int unsigned settings_used  = 1;
  int unsigned cycle_count    = 0;
  int unsigned in_gap         = 0;
  int unsigned out_gap        = 0;
  logic        in_bursty      = 1'b0;
  logic        out_bursty     = 1'b0;

  function automatic time_split_t split_sample(input logic [SAMPLE_W-1:0] sample);
    logic [63:0] mhz;
    logic [63:0] hz;
    logic [63:0] per_ms;
    logic [63:0] total;
    logic [63:0] whole;
    logic [63:0] rem;
    logic [63:0] ms;
    logic [63:0] rem2;
    logic [63:0] us;
    time_split_t r;
    // zero MHz runs as 1 MHz
    mhz = (model_mhz == '0) ? 64'd1 : {54'd0, model_mhz};
    hz = mhz * 64'(US_PER_S);
    per_ms = mhz * 64'(MS_PER_S);
    if (sample < prev_sample) wraps_seen = wraps_seen + 32'd1;
    prev_sample = sample;
    total = {wraps_seen, sample};
    whole = total / hz;
    rem = total - whole * hz;
    ms = rem / per_ms;
    rem2 = rem - ms * per_ms;
    us = rem2 / mhz;
    r.seconds = whole[31:0];
    r.millis = ms[PART_W-1:0];
    r.micros = us[PART_W-1:0];
    r.total_micros = {32'd0, r.seconds} * 64'(US_PER_S) + ms * 64'(MS_PER_S) + us;
    return r;
  endfunction

  task automatic write_mhz(input logic [FREQ_W-1:0] mhz);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.core_mhz <= mhz;
    do @(posedge clk); while (!cfg_ch.ready);
    model_mhz = mhz;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (queued_samples.size() != 0 || pending_times.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_times.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.counter_sample <= '0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        pending_times.push_back(split_sample(in_ch.counter_sample));
        void'(queued_samples.pop_front());
        samples_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_ch.valid <= 1'b0;
          in_gap--;
        end else if (queued_samples.size() != 0 && in_bursty && $urandom_range(0, 5) == 0) begin
          in_ch.valid <= 1'b0;
          in_gap = $urandom_range(0, 2);
        end else if (queued_samples.size() != 0) begin
          in_ch.valid <= 1'b1;
          in_ch.counter_sample <= queued_samples[0];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pending_times.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected result: seconds=%0d millis=%0d micros=%0d total_us=%0d",
                     out_ch.seconds, out_ch.millis, out_ch.micros, out_ch.total_micros);
        end else begin
          if (out_ch.seconds !== pending_times[0].seconds ||
              out_ch.millis !== pending_times[0].millis ||
              out_ch.micros !== pending_times[0].micros ||
              out_ch.total_micros !== pending_times[0].total_micros) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("Result %0d expected: seconds=%0d millis=%0d micros=%0d total_us=%0d",
                       results_seen, pending_times[0].seconds, pending_times[0].millis,
                       pending_times[0].micros, pending_times[0].total_micros);
              $display("Result %0d actual:   seconds=%0d millis=%0d micros=%0d total_us=%0d",
                       results_seen, out_ch.seconds, out_ch.millis, out_ch.micros,
                       out_ch.total_micros);
            end
          end
          void'(pending_times.pop_front());
        end
      end
      if (out_gap > 0) begin
        out_ch.ready <= 1'b0;
        out_gap--;
      end else if (out_bursty && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        out_gap = $urandom_range(0, 2);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [SAMPLE_W-1:0] cursor;
    logic [FREQ_W-1:0]   mhz_plan[NUM_SETTINGS];
    int unsigned         pick;

    in_ch.valid = 1'b0;
    in_ch.counter_sample = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.core_mhz = '0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: boundaries at the reset clock, equal samples, wraps, bit patterns
    in_bursty = 1'b1;
    out_bursty = 1'b1;
    queued_samples = '{32'd0, 32'd0, 32'd1, 32'd167, 32'd168, 32'd167999, 32'd168000,
                       32'd167999999, 32'd168000000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       32'd0, 32'h8000_0000, 32'd5, 32'hFFFF_FFFE, 32'hFFFF_FFFF,
                       32'd1, 32'hAAAA_AAAA, 32'h5555_5555};
    wait_idle();

    mhz_plan[0] = '0;
    mhz_plan[1] = 10'd1;
    mhz_plan[2] = 10'd1023;
    mhz_plan[3] = 10'd1000;
    mhz_plan[4] = FREQ_W'($urandom_range(1, 1000));
    mhz_plan[5] = FREQ_W'($urandom_range(1, 1023));
    mhz_plan[6] = FREQ_RESET;

    cursor = prev_sample;
    for (int p = 0; p < NUM_SETTINGS; p++) begin
      write_mhz(mhz_plan[p]);
      settings_used++;
      // final setting runs with no idling on either side
      in_bursty = (p != NUM_SETTINGS - 1) && ($urandom_range(0, 3) != 0);
      out_bursty = (p != NUM_SETTINGS - 1) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < PHASE_SAMPLES; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) cursor = cursor + $urandom_range(0, 2000);
        else if (pick < 60) cursor = cursor + $urandom_range(0, 1 << 24);
        else if (pick < 72) cursor = cursor + $urandom;
        else if (pick < 80) cursor = cursor - $urandom_range(1, 5000);
        else if (pick < 90) cursor = $urandom;
        queued_samples.push_back(cursor);
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results from %0d counter samples over %0d clock settings",
             results_seen, samples_sent, settings_used);
    $display("Counter wraps tracked: %0d", wraps_seen);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatched results", mismatch_count);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/ccts_pkg.sv
hdl/ccts_if.sv
hdl/ccts_div.sv
hdl/cycle_count_timeline_split_unit.sv
hdl/ccts_checker.sv
bench/testbench.sv
